### sv/sbot_pkg.sv
// ----------------------------------------------------------------------------
// sbot_pkg
// Widths, per-axis record type and register indexes for the segment/box
// overlap test.
// ----------------------------------------------------------------------------
`default_nettype none

package sbot_pkg;

    localparam int COORD_W = 24;
    localparam int DIR_W   = COORD_W + 1;
    localparam int EXT_W   = COORD_W + 1;
    localparam int MID_W   = COORD_W + 3;
    localparam int BOX_W   = MID_W + 1;
    localparam int PROD_W  = MID_W + DIR_W;
    localparam int CMP_W   = PROD_W + 2;
    localparam int IDX_W   = 3;
    localparam int AXES    = 3;

    typedef enum logic [IDX_W-1:0] {
        CFG_MIN_X = 3'd0,
        CFG_MIN_Y = 3'd1,
        CFG_MIN_Z = 3'd2,
        CFG_MAX_X = 3'd3,
        CFG_MAX_Y = 3'd4,
        CFG_MAX_Z = 3'd5
    } t_cfg_idx;

    // doubled midpoint offset, doubled half extent, direction and |direction|
    typedef struct packed {
        logic signed [MID_W-1:0] m;
        logic signed [EXT_W-1:0] e;
        logic signed [DIR_W-1:0] d;
        logic        [DIR_W-1:0] dmag;
    } t_axis;

endpackage

`default_nettype wire

### sv/sbot_axis.sv
// ----------------------------------------------------------------------------
// sbot_axis
// Per-axis front end: doubled midpoint relative to box center, doubled half
// extent, direction magnitude and the box-axis separation flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sbot_axis (
    input  logic signed [sbot_pkg::COORD_W-1:0] i_s,
    input  logic signed [sbot_pkg::DIR_W-1:0]   i_d,
    input  logic signed [sbot_pkg::COORD_W-1:0] i_lo,
    input  logic signed [sbot_pkg::COORD_W-1:0] i_hi,
    output sbot_pkg::t_axis                     o_axis,
    output logic                                o_sep
);
    import sbot_pkg::*;

    logic signed [MID_W-1:0] m;
    logic signed [EXT_W-1:0] e;
    logic        [DIR_W-1:0] dmag;
    logic        [MID_W-1:0] mmag;
    logic signed [BOX_W-1:0] rhs;
    logic signed [BOX_W-1:0] lhs;

    always_comb begin
        m    = MID_W'(i_s) + MID_W'(i_s) + MID_W'(i_d) - MID_W'(i_lo) - MID_W'(i_hi);
        e    = EXT_W'(i_hi) - EXT_W'(i_lo);
        dmag = i_d[DIR_W-1] ? DIR_W'(-i_d) : DIR_W'(i_d);
        mmag = m[MID_W-1] ? MID_W'(-m) : MID_W'(m);
        rhs  = BOX_W'(e) + BOX_W'($signed({1'b0, dmag}));
        lhs  = $signed({1'b0, mmag});
        o_sep = rhs < lhs;
        o_axis.m    = m;
        o_axis.e    = e;
        o_axis.d    = i_d;
        o_axis.dmag = dmag;
    end

endmodule

`default_nettype wire

### sv/sbot_cross.sv
// ----------------------------------------------------------------------------
// sbot_cross
// One cross-product axis: registered products, then the compare
// |Ma*Db - Mb*Da| > Ea*|Db| + Eb*|Da|.
// ----------------------------------------------------------------------------
`default_nettype none

module sbot_cross (
    input  logic            i_clk,
    input  sbot_pkg::t_axis i_a,
    input  sbot_pkg::t_axis i_b,
    output logic            o_sep
);
    import sbot_pkg::*;

    logic signed [PROD_W-1:0] r_p_ab, n_p_ab;
    logic signed [PROD_W-1:0] r_p_ba, n_p_ba;
    logic signed [PROD_W-1:0] r_q_a,  n_q_a;
    logic signed [PROD_W-1:0] r_q_b,  n_q_b;

    logic signed [CMP_W-1:0] diff;
    logic signed [CMP_W-1:0] lhs;
    logic signed [CMP_W-1:0] rhs;

    always_comb begin
        n_p_ab = PROD_W'(i_a.m) * PROD_W'(i_b.d);
        n_p_ba = PROD_W'(i_b.m) * PROD_W'(i_a.d);
        n_q_a  = PROD_W'(i_a.e) * PROD_W'($signed({1'b0, i_b.dmag}));
        n_q_b  = PROD_W'(i_b.e) * PROD_W'($signed({1'b0, i_a.dmag}));
    end

    always_ff @(posedge i_clk) begin
        r_p_ab <= n_p_ab;
        r_p_ba <= n_p_ba;
        r_q_a  <= n_q_a;
        r_q_b  <= n_q_b;
    end

    always_comb begin
        diff  = CMP_W'(r_p_ab) - CMP_W'(r_p_ba);
        lhs   = diff[CMP_W-1] ? -diff : diff;
        rhs   = CMP_W'(r_q_a) + CMP_W'(r_q_b);
        o_sep = rhs < lhs;
    end

endmodule

`default_nettype wire

### sv/segment_box_overlap_test.sv
// ----------------------------------------------------------------------------
// segment_box_overlap_test
// Separating-axis test of a segment (start, direction) against the
// axis-aligned box held in the configuration registers.
// ----------------------------------------------------------------------------
//  channel   signals                               transaction
//  command   i_start, o_busy, i_start_*, i_dir_*   i_start high, o_busy low
//  result    o_done, o_hit                         o_done high, one cycle
//  config    i_cfg_we, i_cfg_idx, i_cfg_data       i_cfg_we high
//
//  One segment per cycle; o_busy is always low. The hit flag passes
//  through the input register, axis setup, product registers and result
//  register. Reset clears the box to all zero and drops any transaction
//  in flight. The receiver cannot stall; o_done is a strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_box_overlap_test (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic signed [sbot_pkg::COORD_W-1:0] i_start_x,
    input  logic signed [sbot_pkg::COORD_W-1:0] i_start_y,
    input  logic signed [sbot_pkg::COORD_W-1:0] i_start_z,
    input  logic signed [sbot_pkg::DIR_W-1:0]   i_dir_x,
    input  logic signed [sbot_pkg::DIR_W-1:0]   i_dir_y,
    input  logic signed [sbot_pkg::DIR_W-1:0]   i_dir_z,
    output logic                                o_done,
    output logic                                o_hit,
    input  logic                                i_cfg_we,
    input  logic [sbot_pkg::IDX_W-1:0]          i_cfg_idx,
    input  logic [sbot_pkg::COORD_W-1:0]        i_cfg_data
);
    import sbot_pkg::*;

    logic signed [COORD_W-1:0] r_box_lo [AXES];
    logic signed [COORD_W-1:0] r_box_hi [AXES];

    logic signed [COORD_W-1:0] r_s [AXES];
    logic signed [DIR_W-1:0]   r_d [AXES];
    logic                      r_v1;

    t_axis       n_ax [AXES];
    t_axis       r_ax [AXES];
    logic [AXES-1:0] n_bsep;
    logic        r_bsep1;
    logic        r_v2;
    logic        r_bsep2;
    logic        r_v3;
    logic [AXES-1:0] csep;
    logic        n_hit;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) begin
                r_box_lo[i] <= '0;
                r_box_hi[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MIN_X: r_box_lo[0] <= i_cfg_data;
                CFG_MIN_Y: r_box_lo[1] <= i_cfg_data;
                CFG_MIN_Z: r_box_lo[2] <= i_cfg_data;
                CFG_MAX_X: r_box_hi[0] <= i_cfg_data;
                CFG_MAX_Y: r_box_hi[1] <= i_cfg_data;
                CFG_MAX_Z: r_box_hi[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_s[0] <= i_start_x;
            r_s[1] <= i_start_y;
            r_s[2] <= i_start_z;
            r_d[0] <= i_dir_x;
            r_d[1] <= i_dir_y;
            r_d[2] <= i_dir_z;
        end
    end

    for (genvar g = 0; g < AXES; g++) begin : g_axis
        sbot_axis u_axis (
            .i_s    (r_s[g]),
            .i_d    (r_d[g]),
            .i_lo   (r_box_lo[g]),
            .i_hi   (r_box_hi[g]),
            .o_axis (n_ax[g]),
            .o_sep  (n_bsep[g])
        );
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < AXES; i++) begin
            r_ax[i] <= n_ax[i];
        end
        r_bsep1 <= |n_bsep;
        r_bsep2 <= r_bsep1;
    end

    // cross axes (y,z), (x,z), (x,y)
    sbot_cross u_cross_yz (.i_clk(i_clk), .i_a(r_ax[1]), .i_b(r_ax[2]), .o_sep(csep[0]));
    sbot_cross u_cross_xz (.i_clk(i_clk), .i_a(r_ax[0]), .i_b(r_ax[2]), .o_sep(csep[1]));
    sbot_cross u_cross_xy (.i_clk(i_clk), .i_a(r_ax[0]), .i_b(r_ax[1]), .o_sep(csep[2]));

    assign n_hit = r_v3 && !r_bsep2 && !(|csep);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            o_done <= 1'b0;
            o_hit  <= 1'b0;
        end else begin
            r_v1   <= i_start && !o_busy;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            o_done <= r_v3;
            o_hit  <= n_hit;
        end
    end

endmodule

`default_nettype wire

### sv/sbot_chk.sv
// ----------------------------------------------------------------------------
// sbot_chk
// Port-level checks on the segment/box overlap test, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sbot_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_done,
    input logic o_hit
);

    // never stalls the command side
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("busy raised");

    // exactly one result strobe for each command, and none without one
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3)
         && $past(i_rst_n, 4))
        |-> (o_done == ($past(i_start, 4) && !$past(o_busy, 4))))
        else $error("result strobe does not match command four cycles back");

    // hit only shows with its strobe
    a_hit_qual: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> o_done)
        else $error("hit without done");

endmodule

bind segment_box_overlap_test sbot_chk u_sbot_chk (.*);

`default_nettype wire
